// ----- design/pwsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority work-stealing deques package
// Shared codes, field widths and default sizes for the deque bank.
// ----------------------------------------------------------------------------
package pwsd_pkg;

  localparam int unsigned LevelsDefault    = 8;
  localparam int unsigned CapacityDefault  = 64;
  localparam int unsigned ItemWidthDefault = 32;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned LVL_SEL_W = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TOTAL_W   = 10;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

endpackage

// ----- design/pwsd_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Slot memory
// Single-port synchronous memory holding the items of all levels.
// ----------------------------------------------------------------------------
module pwsd_slot_mem #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/priority_work_stealing_deques_core.sv -----
// ----------------------------------------------------------------------------
// Priority work-stealing deques core
// Bank of per-level double-ended queues sharing one slot memory. Push adds
// at a level's bottom, pop takes the bottom of the first non-empty active
// level, and steal takes the top of a named level.
//
//   Channel  Signals                                      Direction
//   in       in_valid_i, in_stall_o, op_i, level_sel_i,   request in
//            work_in_i
//   out      out_valid_o, out_stall_i, status_o,          result out
//            work_out_o, level_out_o, total_count_o
//   cfg      cfg_we_i, cfg_wdata_i                        register write
//
// Pointers and counts update when a request is accepted, and the slot memory
// read data moves from the memory's read register into the output register in the next cycle.
// No new request is taken while that read is still in flight.
// A stalled result blocks new requests until it is taken.
// Reset clears all counts and pointers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_work_stealing_deques_core
  import pwsd_pkg::*;
#(
  parameter int unsigned LEVELS         = LevelsDefault,
  parameter int unsigned LEVEL_CAPACITY = CapacityDefault,
  parameter int unsigned ITEM_WIDTH     = ItemWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [LVL_SEL_W-1:0] level_sel_i,
  input  logic [WORD_W-1:0]    work_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [WORD_W-1:0]    work_out_o,
  output logic [LVL_SEL_W-1:0] level_out_o,
  output logic [TOTAL_W-1:0]   total_count_o
);

  localparam int unsigned DEPTH  = LEVELS * LEVEL_CAPACITY;
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TOP_W  = $clog2(LEVEL_CAPACITY);
  localparam int unsigned CNT_W  = $clog2(LEVEL_CAPACITY + 1);
  localparam int unsigned PW     = $clog2(2 * LEVEL_CAPACITY);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned TOT_W  = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q [LEVELS];
  logic [TOP_W-1:0] top_q   [LEVELS];
  logic [TOT_W-1:0] total_q;
  logic [CFG_W-1:0] active_q;
  logic             s1_q;
  logic             take_q;
  logic             out_valid_q;

  logic [STATUS_W-1:0]  status_q;
  logic [WORD_W-1:0]    work_q;
  logic [LVL_SEL_W-1:0] level_q;
  logic [TOTAL_W-1:0]   out_total_q;

  logic                 accept;
  logic [31:0]          sel_ext;
  logic                 sel_ok;
  logic [LVL_W-1:0]     sel_idx;
  logic                 pop_found;
  logic [LVL_W-1:0]     pop_idx;
  logic [31:0]          pop_ext;
  logic [LVL_W-1:0]     idx;
  logic                 idx_ok;
  logic [CNT_W-1:0]     cur_cnt;
  logic [TOP_W-1:0]     cur_top;
  logic                 push_ok;
  logic                 take_ok;
  logic [STATUS_W-1:0]  status_d;
  logic [LVL_SEL_W-1:0] level_d;
  logic [PW-1:0]        pos_raw;
  logic [PW-1:0]        pos_mod;
  logic [TOP_W-1:0]     pos;
  logic [31:0]          addr_ext;
  logic [ADDR_W-1:0]    addr;
  logic [TOP_W-1:0]     top_next;
  logic [TOT_W-1:0]     total_d;
  logic [31:0]          total_ext;
  logic [63:0]          wdata_ext;
  logic [ITEM_WIDTH-1:0] wdata;
  logic [ITEM_WIDTH-1:0] rdata;
  logic [63:0]          rdata_ext;

  assign in_stall_o = s1_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    sel_ext   = 32'(level_sel_i);
    sel_ok    = sel_ext < LEVELS;
    sel_idx   = sel_ext[LVL_W-1:0];
    pop_found = 1'b0;
    pop_idx   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(active_q)) && (count_q[i] != '0)) begin
        pop_found = 1'b1;
        pop_idx   = LVL_W'(i);
      end
    end
    pop_ext = 32'(pop_idx);

    idx     = (op_i == OP_POP) ? pop_idx : sel_idx;
    idx_ok  = (op_i == OP_POP) ? pop_found : sel_ok;
    cur_cnt = idx_ok ? count_q[idx] : '0;
    cur_top = idx_ok ? top_q[idx] : '0;

    push_ok  = 1'b0;
    take_ok  = 1'b0;
    status_d = ST_OK;
    level_d  = level_sel_i;
    case (op_i)
      OP_PUSH: begin
        if (sel_ok && (cur_cnt < CNT_W'(LEVEL_CAPACITY))) begin
          push_ok = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_POP: begin
        if (pop_found) begin
          take_ok = 1'b1;
          level_d = pop_ext[LVL_SEL_W-1:0];
        end else begin
          status_d = ST_EMPTY;
          level_d  = '0;
        end
      end
      OP_STEAL: begin
        if (sel_ok && (cur_cnt != '0)) begin
          take_ok = 1'b1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase

    case (op_i)
      OP_STEAL: pos_raw = PW'(cur_top);
      OP_POP:   pos_raw = PW'(cur_top) + PW'(cur_cnt) - PW'(1);
      default:  pos_raw = PW'(cur_top) + PW'(cur_cnt);
    endcase
    pos_mod  = (pos_raw >= PW'(LEVEL_CAPACITY)) ? pos_raw - PW'(LEVEL_CAPACITY) : pos_raw;
    pos      = pos_mod[TOP_W-1:0];
    addr_ext = 32'(idx) * 32'(LEVEL_CAPACITY) + 32'(pos);
    addr     = addr_ext[ADDR_W-1:0];

    top_next = (32'(cur_top) + 32'd1 == 32'(LEVEL_CAPACITY)) ? '0 : cur_top + TOP_W'(1);

    if (push_ok) begin
      total_d = total_q + TOT_W'(1);
    end else if (take_ok) begin
      total_d = total_q - TOT_W'(1);
    end else begin
      total_d = total_q;
    end
    total_ext = 32'(total_d);

    wdata_ext = 64'(work_in_i);
    wdata     = wdata_ext[ITEM_WIDTH-1:0];
    rdata_ext = 64'(rdata);
  end

  pwsd_slot_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (ITEM_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .en_i    (accept & (push_ok | take_ok)),
    .we_i    (push_ok),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        count_q[i] <= '0;
        top_q[i]   <= '0;
      end
      total_q     <= '0;
      active_q    <= ACTIVE_RESET;
      s1_q        <= 1'b0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (accept) begin
        total_q <= total_d;
        if (push_ok) begin
          count_q[idx] <= cur_cnt + CNT_W'(1);
        end
        if (take_ok) begin
          count_q[idx] <= cur_cnt - CNT_W'(1);
          if (op_i == OP_STEAL) begin
            top_q[idx] <= top_next;
          end
        end
      end
      s1_q   <= accept;
      take_q <= accept & take_ok;
      if (s1_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      level_q     <= level_d;
      out_total_q <= total_ext[TOTAL_W-1:0];
    end
    if (s1_q) begin
      work_q <= take_q ? rdata_ext[WORD_W-1:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign work_out_o    = work_q;
  assign level_out_o   = level_q;
  assign total_count_o = out_total_q;

endmodule

// ----- design/pwsd_checker.sv -----
// ----------------------------------------------------------------------------
// Priority work-stealing deques checker
// Port-level assertions on request timing and result contents.
// ----------------------------------------------------------------------------
module pwsd_checker
  import pwsd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [WORD_W-1:0]    work_out_o,
  input logic [LVL_SEL_W-1:0] level_out_o,
  input logic [TOTAL_W-1:0]   total_count_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(work_out_o) && $stable(level_out_o) && $stable(total_count_o))
    else $error("Stalled result was dropped or changed.");

  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_o ##1 out_valid_o)
    else $error("Result did not appear two cycles after the request.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("Request taken while another was in flight.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> work_out_o == '0)
    else $error("Failed request returned a nonzero item.");

endmodule

bind priority_work_stealing_deques_core pwsd_checker u_pwsd_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Priority work-stealing deques core testbench
// Drives push, pop, steal and unused requests through the request channel and
// compares every result against a behavioral mirror of the deque bank. The
// active level count is rewritten between phases while the core is idle.
// Both channels see random idle and stall bursts, except in quiet phases.
// ----------------------------------------------------------------------------
module tb_top
  import pwsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS = LevelsDefault;
  localparam int unsigned CAP    = CapacityDefault;
  localparam int unsigned PHASES = 6;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [LVL_SEL_W-1:0] lvl;
    logic [WORD_W-1:0]    word;
  } deque_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [WORD_W-1:0]    word;
    logic [LVL_SEL_W-1:0] lvl;
    logic [TOTAL_W-1:0]   total;
  } deque_rsp_t;

  logic                 clk_i = 1'b1;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i = '0;
  logic [LVL_SEL_W-1:0] level_sel_i = '0;
  logic [WORD_W-1:0]    work_in_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [WORD_W-1:0]    work_out_o;
  logic [LVL_SEL_W-1:0] level_out_o;
  logic [TOTAL_W-1:0]   total_count_o;

  deque_req_t request_q[$];
  deque_rsp_t due_results[$];
  deque_req_t cur_req;
  deque_rsp_t got_rsp;
  deque_rsp_t want_rsp;

  logic [WORD_W-1:0] slot_mirror [LEVELS][CAP];
  int unsigned       top_mirror [LEVELS];
  int unsigned       count_mirror [LEVELS];
  int unsigned       total_mirror;
  logic [CFG_W-1:0]  active_mirror;

  logic [CFG_W-1:0] active_plan [PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
  int unsigned      random_plan [PHASES] = '{100, 60, 30, 70, 60, 60};

  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_takes = 0;
  int unsigned peak_total = 0;

  priority_work_stealing_deques_core #(
    .LEVELS        (LEVELS),
    .LEVEL_CAPACITY(CAP),
    .ITEM_WIDTH    (ItemWidthDefault)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .level_sel_i  (level_sel_i),
    .work_in_i    (work_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .work_out_o   (work_out_o),
    .level_out_o  (level_out_o),
    .total_count_o(total_count_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic deque_rsp_t deque_apply(deque_req_t r);
    deque_rsp_t  res;
    int unsigned scan;
    int unsigned pos;
    bit          found;
    res.status = ST_OK;
    res.word   = '0;
    res.lvl    = r.lvl;
    found      = 1'b0;
    case (r.op)
      OP_PUSH: begin
        if (count_mirror[r.lvl] >= CAP) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          pos = (top_mirror[r.lvl] + count_mirror[r.lvl]) % CAP;
          slot_mirror[r.lvl][pos] = r.word;
          count_mirror[r.lvl]++;
          total_mirror++;
        end
      end
      OP_POP: begin
        scan = (active_mirror > LEVELS) ? LEVELS : active_mirror;
        for (int i = 0; i < scan && !found; i++) begin
          if (count_mirror[i] != 0) begin
            found = 1'b1;
            count_mirror[i]--;
            total_mirror--;
            pos = (top_mirror[i] + count_mirror[i]) % CAP;
            res.word = slot_mirror[i][pos];
            res.lvl  = LVL_SEL_W'(i);
          end
        end
        if (!found) begin
          res.status = ST_EMPTY;
          res.lvl    = '0;
          empty_takes++;
        end
      end
      OP_STEAL: begin
        if (count_mirror[r.lvl] == 0) begin
          res.status = ST_EMPTY;
          empty_takes++;
        end else begin
          res.word = slot_mirror[r.lvl][top_mirror[r.lvl]];
          top_mirror[r.lvl] = (top_mirror[r.lvl] + 1) % CAP;
          count_mirror[r.lvl]--;
          total_mirror--;
        end
      end
      default: begin
      end
    endcase
    res.total = TOTAL_W'(total_mirror);
    if (total_mirror > peak_total) begin
      peak_total = total_mirror;
    end
    return res;
  endfunction

  task automatic queue_req(logic [OP_W-1:0] op, logic [LVL_SEL_W-1:0] lvl,
                           logic [WORD_W-1:0] word);
    deque_req_t r;
    r.op   = op;
    r.lvl  = lvl;
    r.word = word;
    request_q = {request_q, r};
  endtask

  task automatic wait_quiet();
    while (request_q.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      op_i        <= '0;
      level_sel_i <= '0;
      work_in_i   <= '0;
      src_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results = {due_results, deque_apply(cur_req)};
        accepted_count++;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0 && src_idle_pct != 0 &&
                   $urandom_range(99, 0) < src_idle_pct) begin
        src_gap = $urandom_range(10, 0);
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        in_valid_i  <= 1'b1;
        op_i        <= cur_req.op;
        level_sel_i <= cur_req.lvl;
        work_in_i   <= cur_req.word;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_rsp = '{status_o, work_out_o, level_out_o, total_count_o};
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected result at %0t: status %0d work %h level %0d total %0d",
                     $realtime, got_rsp.status, got_rsp.word, got_rsp.lvl, got_rsp.total);
          end
        end else begin
          want_rsp = due_results.pop_front();
          checked_count++;
          if (got_rsp.status !== want_rsp.status || got_rsp.word !== want_rsp.word ||
              got_rsp.lvl !== want_rsp.lvl || got_rsp.total !== want_rsp.total) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch at %0t: expected status %0d work %h level %0d total %0d",
                       $realtime, want_rsp.status, want_rsp.word, want_rsp.lvl,
                       want_rsp.total);
              $display("              got      status %0d work %h level %0d total %0d",
                       got_rsp.status, got_rsp.word, got_rsp.lvl, got_rsp.total);
            end
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_stall_i <= 1'b1;
      end else if (snk_idle_pct != 0 && $urandom_range(99, 0) < snk_idle_pct) begin
        snk_gap = $urandom_range(10, 0);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned          added;
    int unsigned          len;
    int unsigned          kind;
    int unsigned          pick;
    logic [OP_W-1:0]      op_pick;
    logic [LVL_SEL_W-1:0] lvl_pick;
    logic [LVL_SEL_W-1:0] fill_lvl;

    for (int l = 0; l < LEVELS; l++) begin
      top_mirror[l]   = 0;
      count_mirror[l] = 0;
    end
    total_mirror  = 0;
    active_mirror = ACTIVE_RESET;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= active_plan[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      active_mirror = active_plan[ph];
      @(negedge clk_i);

      src_idle_pct = (ph == 2 || ph == PHASES - 1) ? 0 : 10;
      snk_idle_pct = (ph == 2 || ph == PHASES - 1) ? 0 : 8;

      if (ph == 0) begin
        queue_req(OP_POP, 3'd5, 32'h0000_0000);
        queue_req(OP_STEAL, 3'd4, 32'hFFFF_FFFF);
        queue_req(OP_PUSH, 3'd0, 32'h0000_0000);
        queue_req(OP_PUSH, 3'd7, 32'hFFFF_FFFF);
        queue_req(OP_PUSH, 3'd7, 32'h1234_5678);
        queue_req(OP_PUSH, 3'd3, 32'h8000_0001);
        queue_req(OP_POP, 3'd7, 32'hFFFF_FFFF);
        queue_req(OP_POP, 3'd0, 32'h0000_0000);
        queue_req(OP_STEAL, 3'd7, 32'h0000_0000);
        queue_req(OP_POP, 3'd2, 32'h5A5A_5A5A);
        queue_req(OP_NONE, 3'd6, 32'hDEAD_BEEF);
        queue_req(OP_STEAL, 3'd0, 32'h0000_0000);
        queue_req(OP_PUSH, 3'd5, 32'hAAAA_AAAA);
        queue_req(OP_PUSH, 3'd5, 32'h5555_5555);
        queue_req(OP_STEAL, 3'd5, 32'h0000_0000);
        queue_req(OP_POP, 3'd1, 32'h0000_0000);
        queue_req(OP_POP, 3'd7, 32'h0000_0000);

        // Fill one level past capacity, then walk both ends around the ring.
        fill_lvl = LVL_SEL_W'($urandom_range(7, 0));
        repeat (CAP + 2) queue_req(OP_PUSH, fill_lvl, $urandom());
        repeat (20) queue_req(OP_STEAL, fill_lvl, $urandom());
        repeat (20) queue_req(OP_PUSH, fill_lvl, $urandom());
        repeat (10) queue_req(OP_POP, LVL_SEL_W'($urandom_range(7, 0)), $urandom());
        repeat (50) queue_req(OP_STEAL, fill_lvl, $urandom());
      end

      added = 0;
      while (added < random_plan[ph]) begin
        kind     = $urandom_range(9, 0);
        lvl_pick = LVL_SEL_W'($urandom_range(7, 0));
        len      = 1;
        case (kind)
          0, 1: begin
            op_pick = OP_PUSH;
            len     = $urandom_range(20, 1);
          end
          2: begin
            op_pick = OP_POP;
            len     = $urandom_range(12, 1);
          end
          3: begin
            op_pick = OP_STEAL;
            len     = $urandom_range(12, 1);
          end
          4: begin
            op_pick = OP_W'($urandom_range(3, 0));
          end
          default: begin
            pick = $urandom_range(99, 0);
            if (pick < 45) begin
              op_pick = OP_PUSH;
            end else if (pick < 70) begin
              op_pick = OP_POP;
            end else if (pick < 95) begin
              op_pick = OP_STEAL;
            end else begin
              op_pick = OP_NONE;
            end
          end
        endcase
        for (int j = 0; j < len && added < random_plan[ph]; j++) begin
          queue_req(op_pick, (op_pick == OP_POP) ? LVL_SEL_W'($urandom_range(7, 0)) : lvl_pick,
                    $urandom());
          added++;
        end
      end
    end

    wait_quiet();
    repeat (6) @(posedge clk_i);

    $display("Covered %0d requests over %0d active-level settings, %0d results checked.",
             accepted_count, PHASES, checked_count);
    $display("Saw %0d full rejects, %0d empty takes, peak occupancy %0d, %0d failures.",
             full_rejects, empty_takes, peak_total, fail_count);
    if (fail_count == 0) begin
      $display("priority_work_stealing_deques_core test passed");
    end else begin
      $display("priority_work_stealing_deques_core test failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout with %0d results outstanding.", due_results.size());
    $display("priority_work_stealing_deques_core test failed");
    $finish;
  end

endmodule
